@@ sv/circulant_gf256_mds_classifier_defines.svh @@
// Assertion macros shared by the classifier RTL.
`ifndef CIRCULANT_GF256_MDS_CLASSIFIER_DEFINES_SVH
`define CIRCULANT_GF256_MDS_CLASSIFIER_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define CGM_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CGM_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ sv/cgm_pkg.sv @@
// Package with field types and GF(2^8) arithmetic for the classifier.
`default_nettype none
package cgm_pkg;
   localparam logic [7:0] GfReduce = 8'h1B;
   localparam logic       ModeInv  = 1'b0;
   localparam logic       ModeMds  = 1'b1;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      byte_type coef_a;
      byte_type coef_b;
      byte_type coef_c;
      byte_type coef_d;
   } req_type;

   typedef struct packed {
      byte_type determinant;
      logic     accepted;
      logic     invertible;
      logic     mds;
      logic     equal_pair;
      logic     xor_zero_subset;
      logic     qualifies;
   } rsp_type;

   // Multiply by x and reduce.
   function automatic byte_type gf_xtime(input byte_type v);
      byte_type s;
      s = {v[6:0], 1'b0};
      return v[7] ? (s ^ GfReduce) : s;
   endfunction

   // Shift-and-add GF(2^8) product.
   function automatic byte_type gf_mul(input byte_type x, input byte_type y);
      byte_type acc;
      byte_type t;
      acc = '0;
      t = x;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) acc = acc ^ t;
         t = gf_xtime(t);
      end
      return acc;
   endfunction
endpackage
`default_nettype wire

@@ sv/cgm_if.sv @@
// Valid/ready channel interfaces for request and response items.
`default_nettype none
interface cgm_req_if import cgm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cgm_rsp_if import cgm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/cgm_minors.sv @@
// Stage 1 and 2: products, then 2x2 and 3x3 minors and flags.
`default_nettype none
module cgm_minors import cgm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     in_valid,
   input  wire req_type  in_data,
   output logic          s2_valid,
   output byte_type      m3_ff [4],
   output byte_type      co_ff [4],
   output logic          min_ok_ff,
   output logic          eq_ff,
   output logic          xz_ff
);
   byte_type co [4];
   byte_type p_in [4][4];
   byte_type p_ff [4][4];
   byte_type c1_ff [4];
   logic     v1_ff;
   logic     v2_ff;
   byte_type m3_in [4];
   logic     ok2;
   logic     ok3;

   assign co[0] = in_data.coef_a;
   assign co[1] = in_data.coef_b;
   assign co[2] = in_data.coef_c;
   assign co[3] = in_data.coef_d;

   // All pairwise products of coefficients.
   always_comb begin
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            p_in[i][j] = gf_mul(co[i], co[j]);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
      if (adv) begin
         p_ff  <= p_in;
         c1_ff <= co;
      end
   end

   // M[r][c] = co[(r+c)&3]; 2x2 minor rows r0,r1 cols k0,k1.
   function automatic byte_type d2(input int r0, input int r1, input int k0,
                                   input int k1);
      return p_ff[(r0+k0)&3][(r1+k1)&3] ^ p_ff[(r0+k1)&3][(r1+k0)&3];
   endfunction

   // Every 2x2 and 3x3 minor nonzero; keep the 3x3 minors deleting row 0, column j.
   always_comb begin
      ok2 = 1'b1;
      ok3 = 1'b1;
      for (int r0 = 0; r0 < 4; r0++)
         for (int r1 = r0 + 1; r1 < 4; r1++)
            for (int k0 = 0; k0 < 4; k0++)
               for (int k1 = k0 + 1; k1 < 4; k1++)
                  if (d2(r0, r1, k0, k1) == '0) ok2 = 1'b0;
      for (int j = 0; j < 4; j++) begin
         m3_in[j] = '0;
      end
      // 3x3 minors: all row/col triples, det via row expansion.
      for (int rd = 0; rd < 4; rd++)
         for (int cd = 0; cd < 4; cd++) begin
            automatic int r[3];
            automatic int c[3];
            automatic int nr = 0;
            automatic int nc = 0;
            automatic byte_type v = '0;
            for (int i = 0; i < 4; i++) begin
               if (i != rd) begin r[nr] = i; nr++; end
               if (i != cd) begin c[nc] = i; nc++; end
            end
            v = gf_mul(c1_ff[(r[0]+c[0])&3], d2(r[1], r[2], c[1], c[2])) ^
                gf_mul(c1_ff[(r[0]+c[1])&3], d2(r[1], r[2], c[0], c[2])) ^
                gf_mul(c1_ff[(r[0]+c[2])&3], d2(r[1], r[2], c[0], c[1]));
            if (v == '0) ok3 = 1'b0;
            if (rd == 0) m3_in[cd] = v;
         end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         m3_ff     <= m3_in;
         co_ff     <= c1_ff;
         min_ok_ff <= ok2 && ok3 && (c1_ff[0] != '0) && (c1_ff[1] != '0) &&
                      (c1_ff[2] != '0) && (c1_ff[3] != '0);
         eq_ff <= (c1_ff[0] == c1_ff[1]) || (c1_ff[0] == c1_ff[2]) ||
                  (c1_ff[0] == c1_ff[3]) || (c1_ff[1] == c1_ff[2]) ||
                  (c1_ff[1] == c1_ff[3]) || (c1_ff[2] == c1_ff[3]);
         xz_ff <= ((c1_ff[0] ^ c1_ff[1] ^ c1_ff[2]) == '0) ||
                  ((c1_ff[0] ^ c1_ff[1] ^ c1_ff[3]) == '0) ||
                  ((c1_ff[0] ^ c1_ff[2] ^ c1_ff[3]) == '0) ||
                  ((c1_ff[1] ^ c1_ff[2] ^ c1_ff[3]) == '0) ||
                  ((c1_ff[0] ^ c1_ff[1] ^ c1_ff[2] ^ c1_ff[3]) == '0);
      end
   end
   assign s2_valid = v2_ff;
endmodule
`default_nettype wire

@@ sv/circulant_gf256_mds_classifier.sv @@
// Top level of the circulant GF(2^8) MDS classifier.
// Usage:
// The req channel carries four coefficient bytes of a 4x4 circulant matrix.
// The rsp channel returns one item per request: determinant, invertible,
// mds, equal_pair, xor_zero_subset, accepted and qualifies.
// csr_we/csr_wdata write the one-bit mode register; write only while idle.
// Mode 0 rejects the all-zero input and counts invertibility; mode 1
// rejects any zero coefficient and counts MDS.
// Throughput is one item per cycle while the receiver takes responses, set by the three-stage pipeline:
// products, then 2x2 and 3x3 minors, then the determinant and verdicts.
// When the receiver stalls with the output stage full, the whole pipeline holds in place
// and req_ready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets mode to 0.
`default_nettype none
`include "circulant_gf256_mds_classifier_defines.svh"
module circulant_gf256_mds_classifier import cgm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   cgm_req_if.sink   req,
   cgm_rsp_if.source rsp,
   input  wire logic csr_we,
   input  wire logic csr_wdata
);
   logic     mode_ff;
   logic     adv;
   logic     s2_valid;
   byte_type m3 [4];
   byte_type co [4];
   logic     min_ok;
   logic     eq;
   logic     xz;
   logic     v3_ff;
   rsp_type  out_ff;
   rsp_type  out_in;
   byte_type det;
   logic     any_nz;
   logic     all_nz;

   // Pipeline advances when the output slot is free or being taken.
   assign adv = !v3_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= ModeInv;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   cgm_minors u_minors (
      .clock, .reset, .adv,
      .in_valid (req.valid && adv),
      .in_data  (req.data),
      .s2_valid,
      .m3_ff    (m3),
      .co_ff    (co),
      .min_ok_ff(min_ok),
      .eq_ff    (eq),
      .xz_ff    (xz)
   );

   // Determinant by expansion along row 0.
   always_comb begin
      det = gf_mul(co[0], m3[0]) ^ gf_mul(co[1], m3[1]) ^
            gf_mul(co[2], m3[2]) ^ gf_mul(co[3], m3[3]);
      any_nz = (co[0] != '0) || (co[1] != '0) || (co[2] != '0) || (co[3] != '0);
      all_nz = (co[0] != '0) && (co[1] != '0) && (co[2] != '0) && (co[3] != '0);
      out_in.determinant     = det;
      out_in.invertible      = det != '0;
      out_in.mds             = (det != '0) && min_ok;
      out_in.equal_pair      = eq;
      out_in.xor_zero_subset = eq || xz;
      out_in.accepted        = (mode_ff == ModeMds) ? all_nz : any_nz;
      out_in.qualifies       = out_in.accepted &&
                               ((mode_ff == ModeMds) ? out_in.mds : out_in.invertible);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= s2_valid;
      if (adv) out_ff <= out_in;
   end

   assign rsp.valid = v3_ff;
   assign rsp.data  = out_ff;

   `CGM_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `CGM_ASSERT_IMP(a_mds_inv, clock, reset, rsp.valid && rsp.data.mds,
                   rsp.data.invertible)
   `CGM_ASSERT_IMP(a_qual_acc, clock, reset, rsp.valid && rsp.data.qualifies,
                   rsp.data.accepted)
   `CGM_ASSERT_IMP(a_eq_xz, clock, reset, rsp.valid && rsp.data.equal_pair,
                   rsp.data.xor_zero_subset)
endmodule
`default_nettype wire

@@ sim/tb_circulant_gf256_mds_classifier_checker.sv @@
// Checker that predicts classifier results and compares them with the response channel.
module tb_circulant_gf256_mds_classifier_checker import cgm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   cgm_req_if.sink  req_mon,
   cgm_rsp_if.sink  rsp_mon,
   input wire logic csr_we,
   input wire logic csr_wdata,
   output int       fail_count,
   output int       pending_count,
   output int       result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic mode_shadow;
   rsp_type expected_results[$];

   // Field product with reduction by the AES polynomial.
   function automatic byte_type field_mul(input byte_type x, input byte_type y);
      byte_type acc;
      byte_type t;
      acc = '0;
      t = x;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) acc ^= t;
         t = t[7] ? ({t[6:0], 1'b0} ^ 8'h1B) : {t[6:0], 1'b0};
      end
      return acc;
   endfunction

   // Determinant of the minor picked by row and column masks (order 1 to 4),
   // expanded along the first selected row. Signs vanish in characteristic 2.
   function automatic byte_type minor_det(input byte_type m[4][4], input logic [3:0] rows,
                                          input logic [3:0] cols);
      byte_type acc;
      int top;
      int n;
      logic [3:0] rest;
      acc = '0;
      top = 0;
      n = $countones(rows);
      while (!rows[top]) top++;
      if (n == 1) begin
         for (int j = 0; j < 4; j++)
            if (cols[j]) acc = m[top][j];
         return acc;
      end
      rest = rows;
      rest[top] = 1'b0;
      for (int j = 0; j < 4; j++) begin
         if (cols[j]) begin
            logic [3:0] sub;
            sub = cols;
            sub[j] = 1'b0;
            acc ^= field_mul(m[top][j], minor_det(m, rest, sub));
         end
      end
      return acc;
   endfunction

   // Classify one candidate under the given mode.
   function automatic rsp_type classify(input req_type r, input logic md);
      rsp_type o;
      byte_type co[4];
      byte_type m[4][4];
      logic all_minors;
      co[0] = r.coef_a;
      co[1] = r.coef_b;
      co[2] = r.coef_c;
      co[3] = r.coef_d;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            m[i][j] = co[(i + j) % 4];
      o.determinant = minor_det(m, 4'hF, 4'hF);
      o.invertible = o.determinant != 0;
      all_minors = 1'b1;
      for (int rs = 1; rs < 15; rs++)
         for (int cs = 1; cs < 15; cs++)
            if ($countones(rs[3:0]) == $countones(cs[3:0]))
               if (minor_det(m, rs[3:0], cs[3:0]) == 0) all_minors = 1'b0;
      o.mds = o.invertible && all_minors;
      o.equal_pair = co[0] == co[1] || co[0] == co[2] || co[0] == co[3] ||
                     co[1] == co[2] || co[1] == co[3] || co[2] == co[3];
      o.xor_zero_subset = o.equal_pair || (co[0] ^ co[1] ^ co[2]) == 0 ||
                          (co[0] ^ co[1] ^ co[3]) == 0 || (co[0] ^ co[2] ^ co[3]) == 0 ||
                          (co[1] ^ co[2] ^ co[3]) == 0 ||
                          (co[0] ^ co[1] ^ co[2] ^ co[3]) == 0;
      if (md == ModeMds)
         o.accepted = co[0] != 0 && co[1] != 0 && co[2] != 0 && co[3] != 0;
      else
         o.accepted = (co[0] | co[1] | co[2] | co[3]) != 0;
      o.qualifies = o.accepted && ((md == ModeMds) ? o.mds : o.invertible);
      return o;
   endfunction

   assign pending_count = expected_results.size();

   // Track mode, queue predictions and compare results at each edge.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         mode_shadow <= ModeInv;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_we) mode_shadow <= csr_wdata;
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(classify(req_mon.data, mode_shadow));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ sim/tb_circulant_gf256_mds_classifier.sv @@
// Top of the classifier testbench: clock, reset, stimulus and verdict.
module tb_circulant_gf256_mds_classifier import cgm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;
   int fail_count;
   int pending_count;
   int result_count;
   int stall_cycles;
   int sent_count;
   int idle_cycles;

   cgm_req_if req_ch ();
   cgm_rsp_if rsp_ch ();

   circulant_gf256_mds_classifier i_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   tb_circulant_gf256_mds_classifier_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending_count(pending_count), .result_count(result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls of random length drawn per item, none when (sent_count / 100) % 3 is 1.
   initial begin
      stall_cycles = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_cycles--;
         end else if (rsp_ch.ready && rsp_ch.valid) begin
            stall_cycles = (sent_count / 100) % 3 == 1 ? 0 : $urandom_range(0, 9);
            rsp_ch.ready <= stall_cycles == 0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired");
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Send one item after a random gap and hold it until accepted.
   task automatic send_item(input req_type r);
      int gap;
      gap = ((sent_count / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // Wait for all results, then let the pipeline settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_mode(input logic md);
      csr_we <= 1'b1;
      csr_wdata <= md;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type random_candidate();
      req_type r;
      byte_type pick;
      r = req_type'($urandom);
      pick = byte_type'($urandom_range(0, 255));
      // Often force repeated values, zeros or zero XOR sums.
      case ($urandom_range(0, 7))
         0: r.coef_b = r.coef_a;
         1: r.coef_c = 8'h00;
         2: r.coef_d = r.coef_a ^ r.coef_b ^ r.coef_c;
         3: r.coef_c = r.coef_a ^ r.coef_b;
         4: r = {pick, pick ^ 8'h01, 8'h01, 8'h01};
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      req_type directed[$];
      sent_count = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed candidates: zeros, all ones, the AES column, equal pairs, zero sums.
      directed = '{'{8'h00, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
                   '{8'h02, 8'h03, 8'h01, 8'h01}, '{8'h01, 8'h02, 8'h04, 8'h08},
                   '{8'h00, 8'h01, 8'h00, 8'h00}, '{8'h00, 8'h02, 8'h03, 8'h01},
                   '{8'h80, 8'h40, 8'h20, 8'h10}, '{8'h01, 8'h02, 8'h03, 8'h05},
                   '{8'h11, 8'h22, 8'h33, 8'h44}, '{8'hFF, 8'h00, 8'hFF, 8'h00},
                   '{8'h01, 8'h00, 8'h00, 8'h00}, '{8'h55, 8'hAA, 8'h0F, 8'hF0},
                   '{8'h02, 8'h01, 8'h01, 8'h03}};
      for (int md = 0; md < 2; md++) begin
         write_mode(md[0]);
         foreach (directed[i]) send_item(directed[i]);
         drain();
      end

      // Random phases, switching mode between them.
      for (int ph = 0; ph < 6; ph++) begin
         write_mode(ph % 2 == 1 ? ModeInv : ModeMds);
         repeat (125) send_item(random_candidate());
         drain();
      end

      $display("Sent %0d candidates in both modes, %0d results checked.",
               sent_count, result_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+sv
sv/cgm_pkg.sv
sv/cgm_if.sv
sv/cgm_minors.sv
sv/circulant_gf256_mds_classifier.sv
sim/tb_circulant_gf256_mds_classifier_checker.sv
sim/tb_circulant_gf256_mds_classifier.sv
